// ----- hdl/imhu_pkg.sv -----
// Shared types and constants of the indexed min-heap update unit.
package imhu_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int ID_BITS_DEF  = 16;
	localparam int KEY_BITS_DEF = 32;

	localparam int KIND_W   = 2;
	localparam int POS_W    = 10;
	localparam int KEYIN_W  = 32;
	localparam int IDIN_W   = 16;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 11;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FND  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_LAST_RD,
		S_LAST_WAIT,
		S_MOVE_WR,
		S_UP_RD,
		S_UP_WAIT,
		S_UP_CMP,
		S_DN_RD_L,
		S_DN_RD_R,
		S_DN_WAIT,
		S_DN_CMP,
		S_SWAP_A,
		S_SWAP_B,
		S_TOP_RD,
		S_TOP_WAIT,
		S_RESULT
	} imhu_state_t;

	// Datapath commands issued by the controller.
	typedef struct packed {
		logic latch_in;     // capture the input item
		logic wr_new;       // write the new entry at the fill-count or input position slot
		logic wr_move;      // write the held last entry at the work slot
		logic cnt_inc;
		logic cnt_dec;
		logic set_work_pos; // work slot := input position
		logic set_work_cnt; // work slot := fill count (insert)
		logic set_work_fnd; // work slot := found slot
		logic srch_clr;
		logic srch_rd;      // read search slot
		logic srch_adv;
		logic rd_last;      // read slot at the already decremented count (old last entry)
		logic hold_last;    // latch read data as moved entry
		logic rd_work;      // read work slot into A
		logic rd_parent;    // read parent into B
		logic rd_left;
		logic rd_right;
		logic cap_a;
		logic cap_b;
		logic cap_c;
		logic up_mode;      // swap target is parent
		logic pick_right;   // swap target is right child
		logic swap_a;       // write B (up) or picked child C (down) at work slot
		logic swap_b;       // write A entry at target, move work slot
		logic dn_start;     // work slot := start slot
		logic rd_top;
		logic cap_top;
		logic set_status;
		logic [STATUS_W-1:0] status;
	} imhu_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic full;
		logic pos_bad;
		logic srch_hit;
		logic srch_end;
		logic fnd_is_last;
		logic at_root;
		logic a_less_b;     // work entry orders before parent: swap up
		logic has_left;
		logic has_right;
		logic c_less_b;     // right child < left child
		logic pick_less_a;
		logic empty;
	} imhu_stat_t;

endpackage

// ----- hdl/indexed_min_heap_update_unit.sv -----
// Top level of the indexed min-heap update unit.
// Insert/change write the item, then sift it up past each parent it orders before and,
//   once it stops, down past its smaller child; delete first searches the slots in order
//   and moves the last entry into the found slot unless the found slot is the last one.
// Throughput: one item at a time; the next item is taken the cycle after the result is taken.
// Reset: arst_n clears the entry count and control; slot memory is not cleared.
module indexed_min_heap_update_unit #(
	parameter int CAPACITY = imhu_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = imhu_pkg::ID_BITS_DEF,
	parameter int KEY_BITS = imhu_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// kind[1:0], position[11:2], cost_key[43:12], id_first[59:44], id_second[75:60]
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], entry_total[12:2], top_key[44:13], top_id_first[60:45],
	// top_id_second[76:61]
	output logic [79:0] m_tdata
);
	import imhu_pkg::*;

	imhu_cmd_t  cmd;
	imhu_stat_t st;
	logic       busy;
	logic       in_fire, out_fire;
	logic [STATUS_W-1:0] status;
	logic [TOTAL_W-1:0]  total;
	logic [KEYIN_W-1:0]  top_key;
	logic [IDIN_W-1:0]   top_ida, top_idb;

	// accept an item only when idle
	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	imhu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.st(st), .cmd(cmd), .busy(busy), .res_valid(m_tvalid)
	);

	imhu_dp #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS), .KEY_BITS(KEY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_kind(s_tdata[1:0]), .in_position(s_tdata[11:2]),
		.in_key(s_tdata[43:12]), .in_ida(s_tdata[59:44]), .in_idb(s_tdata[75:60]),
		.st(st), .status(status), .total(total),
		.top_key(top_key), .top_ida(top_ida), .top_idb(top_idb)
	);

	assign m_tdata = {3'b0, top_idb, top_ida, top_key, total, status};

	// no item is taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> !s_tready)
		else $error("item accepted while result pending");
	// an empty heap reports zero top key and first id
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && total == '0) |-> (top_key == '0 && top_ida == '0))
		else $error("empty heap reports nonzero top");
	// entry count never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		{21'b0, total} <= CAPACITY)
		else $error("entry count above capacity");
endmodule

// ----- hdl/imhu_ram.sv -----
// Generic single-port RAM with registered read.
module imhu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hdl/imhu_ctrl.sv -----
// Controller state machine of the min-heap update unit.
module imhu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic                 out_fire,
	input  imhu_pkg::imhu_stat_t st,
	output imhu_pkg::imhu_cmd_t  cmd,
	output logic                 busy,
	output logic                 res_valid
);
	import imhu_pkg::*;

	imhu_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_fire) state_d = S_DECODE;
			S_DECODE: begin
				case (st.kind)
					KIND_INSERT: state_d = st.full ? S_TOP_RD : S_UP_RD;
					KIND_CHANGE: state_d = st.pos_bad ? S_TOP_RD : S_UP_RD;
					KIND_DELETE: state_d = S_SRCH_RD;
					default:     state_d = S_TOP_RD;
				endcase
			end
			S_SRCH_RD:   state_d = S_SRCH_CHK;
			S_SRCH_CHK: begin
				if (st.srch_end) state_d = S_TOP_RD;
				else if (st.srch_hit) state_d = st.fnd_is_last ? S_TOP_RD : S_LAST_RD;
				else state_d = S_SRCH_RD;
			end
			S_LAST_RD:   state_d = S_LAST_WAIT;
			S_LAST_WAIT: state_d = S_MOVE_WR;
			S_MOVE_WR:   state_d = S_UP_RD;
			S_UP_RD:     state_d = st.at_root ? S_DN_RD_L : S_UP_WAIT;
			S_UP_WAIT:   state_d = S_UP_CMP;
			S_UP_CMP:    state_d = st.a_less_b ? S_SWAP_A : S_DN_RD_L;
			S_DN_RD_L:   state_d = st.has_left ? S_DN_RD_R : S_TOP_RD;
			S_DN_RD_R:   state_d = S_DN_WAIT;
			S_DN_WAIT:   state_d = S_DN_CMP;
			S_DN_CMP:    state_d = st.pick_less_a ? S_SWAP_A : S_TOP_RD;
			S_SWAP_A:    state_d = S_SWAP_B;
			S_SWAP_B:    state_d = S_UP_RD;
			S_TOP_RD:    state_d = S_TOP_WAIT;
			S_TOP_WAIT:  state_d = S_RESULT;
			S_RESULT:    if (out_fire) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// up/down phase flag: set while sifting up, cleared on entering down phase
	logic up_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= 1'b0;
		end else if (state_q == S_DECODE || state_q == S_MOVE_WR) begin
			up_q <= 1'b1;
		end else if ((state_q == S_UP_RD && st.at_root) ||
			     (state_q == S_UP_CMP && !st.a_less_b)) begin
			up_q <= 1'b0;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.status = ST_OK;
		cmd.up_mode = up_q;
		case (state_q)
			S_IDLE: cmd.latch_in = in_fire;
			S_DECODE: begin
				cmd.set_status = 1'b1;
				cmd.srch_clr = 1'b1;
				case (st.kind)
					KIND_INSERT: begin
						if (st.full) cmd.status = ST_FULL;
						else begin
							cmd.set_work_cnt = 1'b1;
							cmd.wr_new = 1'b1;
							cmd.cnt_inc = 1'b1;
						end
					end
					KIND_CHANGE: begin
						if (st.pos_bad) cmd.status = ST_BAD_POS;
						else begin
							cmd.set_work_pos = 1'b1;
							cmd.wr_new = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_SRCH_RD: cmd.srch_rd = 1'b1;
			S_SRCH_CHK: begin
				cmd.srch_adv = 1'b1;
				if (st.srch_end) begin
					cmd.set_status = 1'b1;
					cmd.status = ST_NOT_FND;
				end else if (st.srch_hit) begin
					cmd.set_work_fnd = 1'b1;
					cmd.cnt_dec = 1'b1;
				end
			end
			S_LAST_RD:   cmd.rd_last = 1'b1;
			S_LAST_WAIT: cmd.hold_last = 1'b1;
			S_MOVE_WR:   cmd.wr_move = 1'b1;
			S_UP_RD: begin
				cmd.rd_work = 1'b1;
				cmd.dn_start = st.at_root;
			end
			S_UP_WAIT: begin
				cmd.cap_a = 1'b1;
				cmd.rd_parent = 1'b1;
			end
			S_UP_CMP: begin
				cmd.cap_b = 1'b1;
				cmd.dn_start = !st.a_less_b;
			end
			S_DN_RD_L: begin
				cmd.cap_a = 1'b1;
				cmd.rd_left = 1'b1;
			end
			S_DN_RD_R: begin
				cmd.cap_b = 1'b1;
				cmd.rd_right = 1'b1;
			end
			S_DN_WAIT: begin
				cmd.rd_right = 1'b1;
			end
			S_DN_CMP: begin
				cmd.cap_c = 1'b1;
				cmd.pick_right = st.has_right && st.c_less_b;
			end
			S_SWAP_A: cmd.swap_a = 1'b1;
			S_SWAP_B: cmd.swap_b = 1'b1;
			S_TOP_RD: cmd.rd_top = 1'b1;
			S_TOP_WAIT: cmd.cap_top = 1'b1;
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_RESULT);
endmodule

// ----- hdl/imhu_dp.sv -----
// Datapath of the min-heap update unit: slot storage, compare and registers.
module imhu_dp #(
	parameter int CAPACITY = imhu_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = imhu_pkg::ID_BITS_DEF,
	parameter int KEY_BITS = imhu_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  imhu_pkg::imhu_cmd_t            cmd,
	input  logic [imhu_pkg::KIND_W-1:0]    in_kind,
	input  logic [imhu_pkg::POS_W-1:0]     in_position,
	input  logic [imhu_pkg::KEYIN_W-1:0]   in_key,
	input  logic [imhu_pkg::IDIN_W-1:0]    in_ida,
	input  logic [imhu_pkg::IDIN_W-1:0]    in_idb,
	output imhu_pkg::imhu_stat_t           st,
	output logic [imhu_pkg::STATUS_W-1:0]  status,
	output logic [imhu_pkg::TOTAL_W-1:0]   total,
	output logic [imhu_pkg::KEYIN_W-1:0]   top_key,
	output logic [imhu_pkg::IDIN_W-1:0]    top_ida,
	output logic [imhu_pkg::IDIN_W-1:0]    top_idb
);
	import imhu_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + 2 * ID_BITS;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [ID_BITS-1:0]  ida;
		logic [ID_BITS-1:0]  idb;
	} entry_t;

	function automatic logic less(input entry_t a, input entry_t b);
		logic signed [KEY_BITS-1:0] ka, kb;
		ka = a.key;
		kb = b.key;
		if (ka != kb) return ka < kb;
		if (a.ida != b.ida) return a.ida < b.ida;
		return a.idb < b.idb;
	endfunction

	logic [KIND_W-1:0] kind_q;
	logic [POS_W-1:0]  pos_q;
	entry_t            new_q, move_q, a_q, b_q, c_q, top_q;
	logic [CW-1:0]     cnt_q, srch_q;
	logic [AW-1:0]     work_q, tgt_q;
	logic [STATUS_W-1:0] status_q;
	logic              top_ok_q;

	logic          we;
	logic [AW-1:0] addr;
	entry_t        wdata, rdata;

	logic [CW:0] left_w, right_w;
	assign left_w  = (CW+1)'({work_q, 1'b1});
	assign right_w = left_w + 1'b1;
	logic [AW-1:0] parent_w;
	assign parent_w = AW'((work_q - 1'b1) >> 1);

	always_comb begin
		we    = 1'b0;
		addr  = work_q;
		wdata = new_q;
		if (cmd.wr_new) begin
			we = 1'b1;
			addr = cmd.set_work_cnt ? cnt_q[AW-1:0] : pos_q[AW-1:0];
			wdata = new_q;
		end else if (cmd.wr_move) begin
			we = 1'b1;
			wdata = move_q;
		end else if (cmd.swap_a) begin
			we = 1'b1;
			wdata = cmd.up_mode ? b_q : c_q;
		end else if (cmd.swap_b) begin
			we = 1'b1;
			addr = tgt_q;
			wdata = a_q;
		end else if (cmd.srch_rd) begin
			addr = srch_q[AW-1:0];
		end else if (cmd.rd_last) begin
			addr = AW'(cnt_q);
		end else if (cmd.rd_work) begin
			addr = work_q;
		end else if (cmd.rd_parent) begin
			addr = parent_w;
		end else if (cmd.rd_left) begin
			addr = AW'(left_w);
		end else if (cmd.rd_right) begin
			addr = AW'(right_w);
		end else if (cmd.rd_top) begin
			addr = '0;
		end
	end

	imhu_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// search read data lands in the following cycle; check on the registered data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			srch_q   <= '0;
			status_q <= ST_OK;
			top_ok_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
			if (cmd.cnt_dec) cnt_q <= cnt_q - 1'b1;
			if (cmd.srch_clr) srch_q <= '0;
			else if (cmd.srch_adv) srch_q <= srch_q + 1'b1;
			if (cmd.set_status) status_q <= cmd.status;
			if (cmd.cap_top) top_ok_q <= !st.empty;
		end
	end

	// c_q holds the picked child for swap: chosen at compare time
	entry_t pick_w;
	assign pick_w = (st.has_right && less(rdata, b_q)) ? rdata : b_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			kind_q     <= in_kind;
			pos_q      <= in_position;
			new_q.key  <= KEY_BITS'($signed(in_key));
			new_q.ida  <= ID_BITS'(in_ida);
			new_q.idb  <= ID_BITS'(in_idb);
		end
		if (cmd.set_work_cnt) work_q <= cnt_q[AW-1:0];
		if (cmd.set_work_pos) work_q <= pos_q[AW-1:0];
		if (cmd.set_work_fnd) work_q <= srch_q[AW-1:0];
		if (cmd.hold_last) move_q <= rdata;
		if (cmd.cap_a) a_q <= rdata;
		if (cmd.cap_b) b_q <= rdata;
		if (cmd.cap_c) c_q <= pick_w;
		if (cmd.dn_start) work_q <= work_q;
		if (cmd.rd_parent) tgt_q <= parent_w;
		if (cmd.cap_c) begin
			if (cmd.pick_right) tgt_q <= AW'(right_w);
			else tgt_q <= AW'(left_w);
		end
		if (cmd.swap_b) work_q <= tgt_q;
		if (cmd.cap_top) top_q <= rdata;
	end

	assign st.kind        = kind_q;
	assign st.full        = (cnt_q >= CW'(CAPACITY));
	assign st.pos_bad     = ({{(CW > POS_W ? CW - POS_W : 0){1'b0}}, pos_q} >= cnt_q);
	assign st.srch_end    = (srch_q >= cnt_q);
	assign st.srch_hit    = (rdata.ida == new_q.ida) && (rdata.idb == new_q.idb);
	assign st.fnd_is_last = (srch_q == cnt_q - 1'b1);
	assign st.at_root     = (work_q == '0);
	assign st.a_less_b    = less(a_q, rdata);
	assign st.has_left    = (left_w < (CW+1)'(cnt_q));
	assign st.has_right   = (right_w < (CW+1)'(cnt_q));
	assign st.c_less_b    = less(rdata, b_q);
	assign st.pick_less_a = less(pick_w, a_q);
	assign st.empty       = (cnt_q == '0);

	assign status  = status_q;
	assign total   = TOTAL_W'(cnt_q);
	assign top_key = top_ok_q ? KEYIN_W'($signed(top_q.key)) : '0;
	assign top_ida = top_ok_q ? IDIN_W'(top_q.ida) : '0;
	assign top_idb = top_ok_q ? IDIN_W'(top_q.idb) : '0;
endmodule
